// ===== hw/rtl/pld_pkg.sv =====
// shared types and constants of the positional list block
`timescale 1ns / 1ps

package pld_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int OP_W         = 3;
	localparam int ST_W         = 3;
	localparam int CNT_OUT_W    = 7;
	localparam int TDATA_W      = 48;
	localparam int CAPACITY_DEF = 64;

	// operation codes carried in the input beat
	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK               = 3'd0,
		ST_INVALID          = 3'd1,
		ST_OOB              = 3'd2,
		ST_EMPTY            = 3'd3,
		ST_INVALID_OR_EMPTY = 3'd4,
		ST_FULL             = 3'd5
	} status_t;

	// shift command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/pld_cell.sv =====
// one storage cell of the list row, shifting towards either neighbour
`timescale 1ns / 1ps

module pld_cell #(
	parameter int CAPACITY = pld_pkg::CAPACITY_DEF,
	parameter int INDEX    = 0
) (
	input  logic                                clk,
	input  pld_pkg::cell_cmd_t                  cmd,
	input  logic [$clog2(CAPACITY)-1:0]         idx,
	input  logic [pld_pkg::DATA_W-1:0]          ins_value,
	input  logic [pld_pkg::DATA_W-1:0]          left,
	input  logic [pld_pkg::DATA_W-1:0]          right,
	output logic [pld_pkg::DATA_W-1:0]          entry,
	output logic [pld_pkg::DATA_W-1:0]          tap
);
	import pld_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic [DATA_W-1:0] entry_q;
	logic              hit;
	logic              after;

	// position of this cell relative to the operation point
	assign hit   = (idx == MY_IDX);
	assign after = (MY_IDX > idx);

	// insert opens a gap at idx, delete closes it from the right
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (hit) begin
				entry_q <= ins_value;
			end else if (after) begin
				entry_q <= left;
			end
		end else if (cmd.del && (hit || after)) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	// only the cell being deleted offers its value to the result
	assign tap   = (cmd.del && hit) ? entry_q : '0;

endmodule

// ===== hw/rtl/pld_ctrl.sv =====
// operation decode: range checks, shift point and next entry count
`timescale 1ns / 1ps

module pld_ctrl #(
	parameter int CAPACITY = pld_pkg::CAPACITY_DEF
) (
	input  logic [pld_pkg::OP_W-1:0]            op,
	input  logic [pld_pkg::POS_W-1:0]           position,
	input  logic [$clog2(CAPACITY+1)-1:0]       count,
	output pld_pkg::cell_cmd_t                  cmd,
	output logic [$clog2(CAPACITY)-1:0]         idx,
	output pld_pkg::status_t                    status,
	output logic [$clog2(CAPACITY+1)-1:0]       next_count
);
	import pld_pkg::*;

	localparam int CW   = $clog2(CAPACITY+1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] cnt_w;
	logic [CMPW-1:0] idx_w;
	logic            full;
	logic            empty;
	logic            pos_zero;

	assign pos_w    = CMPW'(position);
	assign cnt_w    = CMPW'(count);
	assign full     = (count == CW'(CAPACITY));
	assign empty    = (count == '0);
	assign pos_zero = (position == '0);

	// status and shift point per operation
	always_comb begin
		cmd    = '0;
		idx_w  = '0;
		status = ST_OK;
		case (op)
			OP_INS_FRONT: begin
				if (full) status = ST_FULL;
				else cmd.ins = 1'b1;
			end
			OP_INS_BACK: begin
				idx_w = cnt_w;
				if (full) status = ST_FULL;
				else cmd.ins = 1'b1;
			end
			OP_INS_POS: begin
				idx_w = pos_w - CMPW'(1);
				if (pos_zero) status = ST_INVALID;
				else if (pos_w > cnt_w + CMPW'(1)) status = ST_OOB;
				else if (full) status = ST_FULL;
				else cmd.ins = 1'b1;
			end
			OP_DEL_FRONT: begin
				if (empty) status = ST_EMPTY;
				else cmd.del = 1'b1;
			end
			OP_DEL_BACK: begin
				idx_w = cnt_w - CMPW'(1);
				if (empty) status = ST_EMPTY;
				else cmd.del = 1'b1;
			end
			OP_DEL_POS: begin
				idx_w = pos_w - CMPW'(1);
				if (empty || pos_zero) status = ST_INVALID_OR_EMPTY;
				else if (pos_w > cnt_w) status = ST_OOB;
				else cmd.del = 1'b1;
			end
			default: begin
				// unused codes leave the list alone
				status = ST_OK;
			end
		endcase
	end

	// the shift point is below the capacity whenever a shift happens
	assign idx = idx_w[IW-1:0];

	// entry count after the operation
	always_comb begin
		if (cmd.ins) next_count = count + CW'(1);
		else if (cmd.del) next_count = count - CW'(1);
		else next_count = count;
	end

endmodule

// ===== hw/rtl/positional_list_insert_delete.sv =====
// Positional list: ordered store of signed words with insert and delete anywhere.
// The result beat is registered and offered in the cycle after the input beat is accepted.
// Throughput: one beat per cycle unless stalled; the whole cell row shifts on accept.
// The input is ready whenever the output register is empty or being drained.
// Reset (arst_n low) empties the list and drops any pending result at once;
// stored words are not cleared, as only entries below the count are ever read.
`timescale 1ns / 1ps

module positional_list_insert_delete #(
	parameter int CAPACITY = pld_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// op [2:0], value [34:3], position [41:35], zero [47:42]
	input  logic [pld_pkg::TDATA_W-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status [2:0], removed_value [34:3], entry_count [41:35], zero [47:42]
	output logic [pld_pkg::TDATA_W-1:0]   m_tdata
);
	import pld_pkg::*;

	localparam int CW = $clog2(CAPACITY+1);
	localparam int IW = $clog2(CAPACITY);

	logic [OP_W-1:0]   in_op;
	logic [DATA_W-1:0] in_value;
	logic [POS_W-1:0]  in_position;
	logic              accept;

	cell_cmd_t         dec_cmd;
	cell_cmd_t         cell_cmd;
	logic [IW-1:0]     dec_idx;
	status_t           dec_status;
	logic [CW-1:0]     dec_count;

	logic [DATA_W-1:0] ent  [CAPACITY];
	logic [DATA_W-1:0] taps [CAPACITY];
	logic [DATA_W-1:0] removed;

	logic              m_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] removed_q;
	logic [CW-1:0]     count_q;

	// input beat unpacking
	assign in_op       = s_tdata[OP_W-1:0];
	assign in_value    = s_tdata[OP_W +: DATA_W];
	assign in_position = s_tdata[OP_W+DATA_W +: POS_W];

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// decode against the current count
	pld_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.op         (in_op),
		.position   (in_position),
		.count      (count_q),
		.cmd        (dec_cmd),
		.idx        (dec_idx),
		.status     (dec_status),
		.next_count (dec_count)
	);

	// cells shift only on an accepted beat
	assign cell_cmd = accept ? dec_cmd : '0;

	// row of cells, each wired to both neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = ent[i-1];
		end

		if (i == CAPACITY-1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = ent[i+1];
		end

		pld_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cell_cmd),
			.idx       (dec_idx),
			.ins_value (in_value),
			.left      (left_w),
			.right     (right_w),
			.entry     (ent[i]),
			.tap       (taps[i])
		);
	end

	// at most one tap is live, so an or gathers the removed word
	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | taps[i];
		end
	end

	// result register and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
			count_q   <= dec_count;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= dec_status;
			removed_q <= removed;
		end
	end

	// result beat packing
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {
		{(TDATA_W-ST_W-DATA_W-CNT_OUT_W){1'b0}},
		CNT_OUT_W'(count_q),
		removed_q,
		status_q
	};

endmodule

// ===== hw/rtl/pld_check.sv =====
// port-level checks of the positional list, bound to the top level
`timescale 1ns / 1ps

module pld_check #(
	parameter int CAPACITY = pld_pkg::CAPACITY_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pld_pkg::TDATA_W-1:0]   m_tdata
);
	import pld_pkg::*;

	logic [ST_W-1:0]      st;
	logic [DATA_W-1:0]    rem;
	logic [CNT_OUT_W-1:0] cnt;

	assign st  = m_tdata[ST_W-1:0];
	assign rem = m_tdata[ST_W +: DATA_W];
	assign cnt = m_tdata[ST_W+DATA_W +: CNT_OUT_W];

	// a stalled result beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// every accepted input beat gives a result beat in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result beat after accepted input");

	// a removed word only comes with a successful delete
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (rem != '0) |-> (st == ST_OK))
		else $error("removed value with failing status");

	// entry count never exceeds the capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(cnt) <= 32'(CAPACITY)) || (CAPACITY >= 128))
		else $error("entry count beyond capacity");

endmodule

bind positional_list_insert_delete pld_check #(
	.CAPACITY (CAPACITY)
) u_pld_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
// testbench for the positional list: self-checking random and directed stream traffic
`timescale 1ns / 1ps

module tb_top;
	import pld_pkg::*;

	// op field codes past the defined operations, passed through as no-ops
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam int RANDOM_OPS  = 1330;
	localparam int TAIL_OPS    = 150;
	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_AT    = 900;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 10;

	// one result beat, unpacked
	typedef struct {
		status_t          status;
		logic [DATA_W-1:0] removed;
		logic [CNT_OUT_W-1:0] count;
	} list_result_t;

	// mirror of the list contents, with the results still to come
	class list_mirror;
		logic [DATA_W-1:0] stored[$];
		list_result_t      awaited[$];
		int                errors;

		function int size();
			return stored.size();
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// apply one accepted operation and queue the result it must produce
		function void apply_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
				logic [POS_W-1:0] pos);
			list_result_t r;
			int n;
			int p;
			n = stored.size();
			p = pos;
			r.status  = ST_OK;
			r.removed = '0;
			case (op)
				OP_INS_FRONT: begin
					if (n >= CAPACITY_DEF) r.status = ST_FULL;
					else stored.push_front(val);
				end
				OP_INS_BACK: begin
					if (n >= CAPACITY_DEF) r.status = ST_FULL;
					else stored.push_back(val);
				end
				OP_INS_POS: begin
					if (p == 0) r.status = ST_INVALID;
					else if (p > n + 1) r.status = ST_OOB;
					else if (n >= CAPACITY_DEF) r.status = ST_FULL;
					else stored.insert(p - 1, val);
				end
				OP_DEL_FRONT: begin
					if (n == 0) r.status = ST_EMPTY;
					else r.removed = stored.pop_front();
				end
				OP_DEL_BACK: begin
					if (n == 0) r.status = ST_EMPTY;
					else r.removed = stored.pop_back();
				end
				OP_DEL_POS: begin
					if (n == 0 || p == 0) r.status = ST_INVALID_OR_EMPTY;
					else if (p > n) r.status = ST_OOB;
					else begin
						r.removed = stored[p - 1];
						stored.delete(p - 1);
					end
				end
				default: ;
			endcase
			r.count = CNT_OUT_W'(stored.size());
			awaited.push_back(r);
		endfunction

		function void compare(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		// compare a result beat with the oldest awaited result
		function void check_result(logic [TDATA_W-1:0] beat);
			list_result_t r;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result beat, expected none, actual %0h",
					$time, beat);
				return;
			end
			r = awaited.pop_front();
			compare("status", DATA_W'(r.status), DATA_W'(beat[2:0]));
			compare("removed_value", r.removed, beat[34:3]);
			compare("entry_count", DATA_W'(r.count), DATA_W'(beat[41:35]));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;

	list_mirror mirror;
	int         ops_sent;
	int         tx_idle_pct;
	int         rx_stall_pct;
	bit         tail;
	bit         hold_active;
	int         quiet_cycles;

	positional_list_insert_delete i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor both sides: results first, as they belong to earlier operations
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) mirror.check_result(m_tdata);
			if (s_tvalid && s_tready) mirror.apply_op(s_tdata[2:0], s_tdata[34:3], s_tdata[41:35]);
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off, none in the tail
	initial begin
		bit held;
		int k;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && ops_sent >= HOLD_AT) begin
				held = 1'b1;
				hold_active = 1'b1;
				m_tready = 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
				hold_active = 1'b0;
			end else if (!tail && $urandom_range(0, 99) < rx_stall_pct) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
				@(negedge clk);
			end
		end
	end

	// offer one operation and hold it until accepted
	task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {6'd0, pos, val, op};
		do @(posedge clk); while (!s_tready);
		ops_sent++;
	endtask

	// drop valid for a burst, with junk on the data lines
	task automatic idle_gap(input int n);
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata  = TDATA_W'({$urandom, $urandom});
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!tail && !hold_active && $urandom_range(0, 99) < tx_idle_pct)
			idle_gap($urandom_range(1, 12));
	endtask

	// stop offering until every awaited result is out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	// edge cases on an empty list, then a short list built and torn down
	task automatic run_directed();
		send_op(OP_DEL_FRONT, 32'd0, 7'd0);
		send_op(OP_DEL_BACK, 32'd0, 7'd0);
		send_op(OP_DEL_POS, 32'd0, 7'd1);
		send_op(OP_DEL_POS, 32'd0, 7'd0);
		send_op(OP_INS_POS, 32'd5, 7'd0);
		send_op(OP_INS_POS, 32'd6, 7'd2);
		send_op(OP_INS_POS, 32'd7, 7'd127);
		send_op(OP_INS_POS, 32'h8000_0000, 7'd1);
		send_op(OP_INS_FRONT, 32'h7fff_ffff, 7'd0);
		send_op(OP_INS_BACK, 32'd0, 7'd127);
		send_op(OP_INS_POS, 32'hffff_ffff, 7'd4);
		send_op(OP_INS_POS, 32'd1, 7'd2);
		send_op(OP_SPARE_6, 32'hdead_beef, 7'd1);
		send_op(OP_SPARE_7, 32'h1234_5678, 7'd64);
		send_op(OP_DEL_POS, 32'd0, 7'd0);
		send_op(OP_DEL_POS, 32'd0, 7'd6);
		send_op(OP_DEL_POS, 32'hffff_ffff, 7'd127);
		send_op(OP_DEL_POS, 32'd0, 7'd5);
		send_op(OP_DEL_POS, 32'd0, 7'd2);
		send_op(OP_DEL_FRONT, 32'd0, 7'd0);
		send_op(OP_DEL_BACK, 32'd0, 7'd0);
		send_op(OP_DEL_POS, 32'd0, 7'd1);
		send_op(OP_INS_POS, 32'h5555_5555, 7'd1);
	endtask

	// segments that fill, drain or churn the list, with random content
	task automatic run_random();
		op_t ins_ops[4] = '{OP_INS_FRONT, OP_INS_BACK, OP_INS_POS, OP_INS_POS};
		op_t del_ops[4] = '{OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS, OP_DEL_POS};
		logic [DATA_W-1:0] corner_vals[4] = '{32'h7fff_ffff, 32'h8000_0000, 32'd0,
			32'hffff_ffff};
		int idle_choice[4] = '{0, 0, 10, 30};
		int stall_choice[3] = '{0, 10, 30};
		int done;
		int seg_len;
		int ins_pct;
		int mode;
		int n;
		int r;
		bit drained;
		logic [OP_W-1:0] op;
		logic [DATA_W-1:0] val;
		logic [POS_W-1:0] pos;

		done = 0;
		drained = 1'b0;
		while (done < RANDOM_OPS) begin
			// first segment fills the list to capacity
			if (done == 0) begin
				mode = 0;
				seg_len = 150;
			end else begin
				r = $urandom_range(0, 9);
				mode = (r < 4) ? 0 : (r < 7) ? 1 : 2;
				seg_len = $urandom_range(30, 120);
			end
			ins_pct = (mode == 0) ? 90 : (mode == 1) ? 15 : 50;
			tx_idle_pct  = idle_choice[$urandom_range(0, 3)];
			rx_stall_pct = stall_choice[$urandom_range(0, 2)];

			for (int i = 0; i < seg_len && done < RANDOM_OPS; i++) begin
				if (done >= RANDOM_OPS - TAIL_OPS) tail = 1'b1;
				if (!drained && ops_sent >= DRAIN_AT) begin
					drained = 1'b1;
					wait_drained();
				end
				n = mirror.size();

				r = $urandom_range(0, 99);
				if (r < 2) op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
				else if ($urandom_range(0, 99) < ins_pct) op = ins_ops[$urandom_range(0, 3)];
				else op = del_ops[$urandom_range(0, 3)];

				r = $urandom_range(0, 99);
				if (r < 65) pos = POS_W'($urandom_range(0, n + 2));
				else if (r < 80) pos = POS_W'($urandom_range(0, 127));
				else begin
					case ($urandom_range(0, 3))
						0: pos = '0;
						1: pos = POS_W'(n);
						2: pos = POS_W'(n + 1);
						default: pos = 7'd1;
					endcase
				end

				if ($urandom_range(0, 99) < 10) val = corner_vals[$urandom_range(0, 3)];
				else val = $urandom;

				maybe_idle();
				send_op(op, val, pos);
				done++;
			end
		end
	endtask

	// stimulus and end of run
	initial begin
		mirror       = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		ops_sent     = 0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		tail         = 1'b0;
		hold_active  = 1'b0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct  = 20;
		rx_stall_pct = 20;
		run_directed();
		run_random();

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
